[design/tsfm_pkg.sv]
// shared widths, register indexes, reset values and lane type of the touch filter
package tsfm_pkg;

  localparam int unsigned WIN_W  = 12;
  localparam int unsigned LEN_W  = 6;
  localparam int unsigned PIX_W  = 11;
  localparam int unsigned PROD_W = 24;
  localparam int unsigned IDX_W  = 3;

  localparam logic [WIN_W-1:0] MAX_SCREEN = 12'd2048;

  localparam logic [IDX_W-1:0] REG_X_LOW     = 3'd0;
  localparam logic [IDX_W-1:0] REG_X_HIGH    = 3'd1;
  localparam logic [IDX_W-1:0] REG_Y_LOW     = 3'd2;
  localparam logic [IDX_W-1:0] REG_Y_HIGH    = 3'd3;
  localparam logic [IDX_W-1:0] REG_BURST     = 3'd4;
  localparam logic [IDX_W-1:0] REG_ROTATED   = 3'd5;
  localparam logic [IDX_W-1:0] REG_SCREEN_W  = 3'd6;
  localparam logic [IDX_W-1:0] REG_SCREEN_H  = 3'd7;

  localparam logic [WIN_W-1:0] RST_X_LOW    = 12'd300;
  localparam logic [WIN_W-1:0] RST_X_HIGH   = 12'd3750;
  localparam logic [WIN_W-1:0] RST_Y_LOW    = 12'd215;
  localparam logic [WIN_W-1:0] RST_Y_HIGH   = 12'd3440;
  localparam logic [LEN_W-1:0] RST_BURST    = 6'd1;
  localparam logic [WIN_W-1:0] RST_SCREEN_W = 12'd320;
  localparam logic [WIN_W-1:0] RST_SCREEN_H = 12'd240;

  // operands of one mapping lane
  typedef struct packed {
    logic [WIN_W-1:0] size;
    logic [WIN_W-1:0] span;
    logic [WIN_W-1:0] diff;
    logic             pos;
    logic             span_ok;
  } lane_t;

endpackage

[design/tsfm_serial_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
module tsfm_serial_div #(
  parameter int unsigned NUM_W = 24,
  parameter int unsigned DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] trial;

  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, den_r};
    if (!trial[DEN_W+1]) begin
      rem_nxt = trial[DEN_W-1:0];
    end else begin
      rem_nxt = shifted[DEN_W-1:0];
    end
    quo_nxt = {quo_r[NUM_W-2:0], ~trial[DEN_W+1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[design/tsfm_serial_mul.sv]
// bit-serial shift-add multiplier, one multiplier bit per cycle
module tsfm_serial_mul #(
  parameter int unsigned A_W = 12,
  parameter int unsigned B_W = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               done,
  output logic [A_W+B_W-1:0] prod
);

  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic [P_W-1:0]   acc_r, acc_nxt;
  logic [A_W-1:0]   a_r;
  logic [B_W-1:0]   b_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [A_W:0]     upper;

  // add into the top half, then shift the whole product right
  always_comb begin
    upper   = {1'b0, acc_r[P_W-1:B_W]} + (b_r[0] ? {1'b0, a_r} : '0);
    acc_nxt = {upper, acc_r[B_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(B_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {1'b0, b_r[B_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

[design/touch_sample_filter_and_map.sv]
// top level: burst averaging of touch samples and mapping to display pixels
//
//  channel | direction | handshake          | payload
//  in_     | in        | in_valid/in_stall  | in_sample_x, in_sample_y
//  out_    | out       | out_valid/out_stall| out_avg_x/y, out_pixel_x/y, out_none_counted
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a request that does not close a burst is summed without stalling the input, back to back
// a request that closes a burst stalls the input while, per axis lane, a 24-step serial
//   division forms the average, then a 12-step serial multiply and a 24-step serial division
//   form the pixel, each started from its own start state, until the result is loaded
// the next request is accepted once the result is loaded, later while a result waits
// synchronous active-low reset restores the register defaults and clears the sums
// a stalled result holds its register; the next burst is still summed meanwhile
module touch_sample_filter_and_map #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned MAX_BURST   = 50
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [SAMPLE_BITS-1:0]        in_sample_x,
  input  logic [SAMPLE_BITS-1:0]        in_sample_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tsfm_pkg::WIN_W-1:0]    out_avg_x,
  output logic [tsfm_pkg::WIN_W-1:0]    out_avg_y,
  output logic [tsfm_pkg::PIX_W-1:0]    out_pixel_x,
  output logic [tsfm_pkg::PIX_W-1:0]    out_pixel_y,
  output logic                          out_none_counted,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tsfm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [tsfm_pkg::WIN_W-1:0]    cfg_data
);

  localparam int unsigned WIN_W  = tsfm_pkg::WIN_W;
  localparam int unsigned LEN_W  = tsfm_pkg::LEN_W;
  localparam int unsigned PIX_W  = tsfm_pkg::PIX_W;
  localparam int unsigned PROD_W = tsfm_pkg::PROD_W;
  localparam int unsigned CNT_W  = $clog2(MAX_BURST + 1);
  localparam int unsigned SUM_W  = WIN_W + CNT_W;
  localparam int unsigned CMP_W  = (SAMPLE_BITS > WIN_W) ? SAMPLE_BITS : WIN_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_AVG_GO = 3'd1;
  localparam logic [2:0] ST_AVG    = 3'd2;
  localparam logic [2:0] ST_MUL_GO = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_MAP_GO = 3'd5;
  localparam logic [2:0] ST_MAP    = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  // configuration
  logic [WIN_W-1:0] x_low_r, x_high_r, y_low_r, y_high_r;
  logic [WIN_W-1:0] screen_w_r, screen_h_r;
  logic [LEN_W-1:0] burst_len_r;
  logic             rotated_r;
  logic [LEN_W-1:0] burst_wr;

  // accumulation
  logic [SUM_W-1:0] sum_x_r, sum_y_r;
  logic [CNT_W-1:0] counted_r, pairs_r, pairs_nxt;
  logic [CMP_W-1:0] sx_ext, sy_ext;
  logic             in_window, in_acc, burst_end;

  // sequencing and datapath
  logic [2:0]             state_r;
  logic [WIN_W-1:0]       avg_x_r, avg_y_r;
  logic                   none_r;
  tsfm_pkg::lane_t        lane_x_r, lane_y_r, lane_x_nxt, lane_y_nxt;
  logic [WIN_W-1:0]       w_cl, h_cl;
  logic                   div_start, mul_start;
  logic [PROD_W-1:0]      div_num_x, div_num_y, quo_x, quo_y, prod_x, prod_y;
  logic [WIN_W-1:0]       div_den_x, div_den_y;
  logic                   div_done_x, div_done_y, mul_done_x, mul_done_y;
  logic [PIX_W-1:0]       pix_x, pix_y;

  // output register
  logic                   out_valid_r;
  logic [WIN_W-1:0]       out_avg_x_r, out_avg_y_r;
  logic [PIX_W-1:0]       out_pix_x_r, out_pix_y_r;
  logic                   out_none_r;

  function automatic logic [WIN_W-1:0] clamp_size(input logic [WIN_W-1:0] s);
    if (s == '0) begin
      return WIN_W'(1);
    end else if (s > tsfm_pkg::MAX_SCREEN) begin
      return tsfm_pkg::MAX_SCREEN;
    end
    return s;
  endfunction

  function automatic tsfm_pkg::lane_t make_lane(input logic [WIN_W-1:0] v,
                                                input logic [WIN_W-1:0] low,
                                                input logic [WIN_W-1:0] high,
                                                input logic [WIN_W-1:0] size);
    tsfm_pkg::lane_t l;
    l.size    = size;
    l.span    = high - low;
    l.diff    = v - low;
    l.pos     = v > low;
    l.span_ok = high > low;
    return l;
  endfunction

  // size*(v-low)/span clamped to 0..size-1
  function automatic logic [PIX_W-1:0] pix_plain(input tsfm_pkg::lane_t l,
                                                 input logic [PROD_W-1:0] q);
    logic [WIN_W-1:0] top;
    top = l.size - 1'b1;
    if (!l.span_ok || !l.pos) begin
      return '0;
    end else if (q >= PROD_W'(l.size)) begin
      return top[PIX_W-1:0];
    end
    return q[PIX_W-1:0];
  endfunction

  // size minus the scaled position, clamped to 0..size-1
  function automatic logic [PIX_W-1:0] pix_mirror(input tsfm_pkg::lane_t l,
                                                  input logic [PROD_W-1:0] q);
    logic [WIN_W-1:0] top, diff;
    top  = l.size - 1'b1;
    diff = l.size - q[WIN_W-1:0];
    if (!l.span_ok) begin
      return '0;
    end else if (!l.pos || q == '0) begin
      return top[PIX_W-1:0];
    end else if (q >= PROD_W'(l.size)) begin
      return '0;
    end
    return diff[PIX_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign burst_wr  = cfg_data[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_low_r     <= tsfm_pkg::RST_X_LOW;
      x_high_r    <= tsfm_pkg::RST_X_HIGH;
      y_low_r     <= tsfm_pkg::RST_Y_LOW;
      y_high_r    <= tsfm_pkg::RST_Y_HIGH;
      burst_len_r <= tsfm_pkg::RST_BURST;
      rotated_r   <= 1'b0;
      screen_w_r  <= tsfm_pkg::RST_SCREEN_W;
      screen_h_r  <= tsfm_pkg::RST_SCREEN_H;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tsfm_pkg::REG_X_LOW:    x_low_r    <= cfg_data;
        tsfm_pkg::REG_X_HIGH:   x_high_r   <= cfg_data;
        tsfm_pkg::REG_Y_LOW:    y_low_r    <= cfg_data;
        tsfm_pkg::REG_Y_HIGH:   y_high_r   <= cfg_data;
        tsfm_pkg::REG_BURST: begin
          // out-of-range lengths keep the old value
          if (burst_wr != '0 && burst_wr <= LEN_W'(MAX_BURST)) begin
            burst_len_r <= burst_wr;
          end
        end
        tsfm_pkg::REG_ROTATED:  rotated_r  <= cfg_data[0];
        tsfm_pkg::REG_SCREEN_W: screen_w_r <= cfg_data;
        tsfm_pkg::REG_SCREEN_H: screen_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    sx_ext    = CMP_W'(in_sample_x);
    sy_ext    = CMP_W'(in_sample_y);
    in_window = (sx_ext > CMP_W'(x_low_r)) && (sx_ext < CMP_W'(x_high_r)) &&
                (sy_ext > CMP_W'(y_low_r)) && (sy_ext < CMP_W'(y_high_r));
    pairs_nxt = pairs_r + 1'b1;
    burst_end = LEN_W'(pairs_nxt) >= burst_len_r;
  end

  always_comb begin
    w_cl = clamp_size(screen_w_r);
    h_cl = clamp_size(screen_h_r);
    if (rotated_r) begin
      lane_x_nxt = make_lane(avg_y_r, y_low_r, y_high_r, w_cl);
      lane_y_nxt = make_lane(avg_x_r, x_low_r, x_high_r, h_cl);
    end else begin
      lane_x_nxt = make_lane(avg_x_r, x_low_r, x_high_r, w_cl);
      lane_y_nxt = make_lane(avg_y_r, y_low_r, y_high_r, h_cl);
    end
  end

  // the dividers serve the average first, then the pixel scaling
  always_comb begin
    div_start = (state_r == ST_AVG_GO) || (state_r == ST_MAP_GO);
    mul_start = (state_r == ST_MUL_GO);
    if (state_r == ST_AVG_GO) begin
      div_num_x = PROD_W'(sum_x_r);
      div_num_y = PROD_W'(sum_y_r);
      div_den_x = WIN_W'(counted_r);
      div_den_y = WIN_W'(counted_r);
    end else begin
      div_num_x = prod_x;
      div_num_y = prod_y;
      div_den_x = lane_x_r.span;
      div_den_y = lane_y_r.span;
    end
    pix_x = rotated_r ? pix_mirror(lane_x_r, quo_x) : pix_plain(lane_x_r, quo_x);
    pix_y = pix_plain(lane_y_r, quo_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      counted_r   <= '0;
      pairs_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a result leaving while the next one loads keeps valid high
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_window) begin
              sum_x_r   <= sum_x_r + SUM_W'(sx_ext[WIN_W-1:0]);
              sum_y_r   <= sum_y_r + SUM_W'(sy_ext[WIN_W-1:0]);
              counted_r <= counted_r + 1'b1;
            end
            pairs_r <= pairs_nxt;
            if (burst_end) begin
              state_r <= ST_AVG_GO;
            end
          end
        end
        ST_AVG_GO: state_r <= ST_AVG;
        ST_AVG: begin
          if (div_done_x) begin
            sum_x_r   <= '0;
            sum_y_r   <= '0;
            counted_r <= '0;
            pairs_r   <= '0;
            state_r   <= ST_MUL_GO;
          end
        end
        ST_MUL_GO: state_r <= ST_MUL;
        ST_MUL: begin
          if (mul_done_x) begin
            state_r <= ST_MAP_GO;
          end
        end
        ST_MAP_GO: state_r <= ST_MAP;
        ST_MAP: begin
          if (div_done_x) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_AVG && div_done_x) begin
      none_r  <= (counted_r == '0);
      avg_x_r <= (counted_r == '0) ? '0 : quo_x[WIN_W-1:0];
      avg_y_r <= (counted_r == '0) ? '0 : quo_y[WIN_W-1:0];
    end
    if (mul_start) begin
      lane_x_r <= lane_x_nxt;
      lane_y_r <= lane_y_nxt;
    end
    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_avg_x_r <= avg_x_r;
      out_avg_y_r <= avg_y_r;
      out_pix_x_r <= pix_x;
      out_pix_y_r <= pix_y;
      out_none_r  <= none_r;
    end
  end

  tsfm_serial_div #(.NUM_W(PROD_W), .DEN_W(WIN_W)) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num_x),
    .den   (div_den_x),
    .done  (div_done_x),
    .quo   (quo_x)
  );

  tsfm_serial_div #(.NUM_W(PROD_W), .DEN_W(WIN_W)) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num_y),
    .den   (div_den_y),
    .done  (div_done_y),
    .quo   (quo_y)
  );

  tsfm_serial_mul #(.A_W(WIN_W), .B_W(WIN_W)) u_mul_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (lane_x_nxt.size),
    .b     (lane_x_nxt.diff),
    .done  (mul_done_x),
    .prod  (prod_x)
  );

  tsfm_serial_mul #(.A_W(WIN_W), .B_W(WIN_W)) u_mul_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (lane_y_nxt.size),
    .b     (lane_y_nxt.diff),
    .done  (mul_done_y),
    .prod  (prod_y)
  );

  assign out_valid        = out_valid_r;
  assign out_avg_x        = out_avg_x_r;
  assign out_avg_y        = out_avg_y_r;
  assign out_pixel_x      = out_pix_x_r;
  assign out_pixel_y      = out_pix_y_r;
  assign out_none_counted = out_none_r;

`ifndef SYNTHESIS
  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the done step");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_none_counted) |-> (out_avg_x == '0 && out_avg_y == '0))
    else $error("empty burst with nonzero average");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (div_done_x == div_done_y) && (mul_done_x == mul_done_y))
    else $error("axis lanes out of step");

  a_mul_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done_x |-> (state_r == ST_MUL))
    else $error("multiply finished outside its step");
`endif

endmodule

[test/tb_top.sv]
// testbench for the touch sample filter and mapper: bursts of samples against a predicted position
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned WIN_W = tsfm_pkg::WIN_W;
  localparam int unsigned PIX_W = tsfm_pkg::PIX_W;
  localparam int unsigned IDX_W = tsfm_pkg::IDX_W;

  localparam int SAMPLE_W      = 12;
  localparam int BURST_MAX     = 50;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PHASES        = 12;
  localparam int PAIRS_PER_PHASE = 75;

  typedef struct packed {
    logic [WIN_W-1:0] avg_x;
    logic [WIN_W-1:0] avg_y;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             none;
  } position_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample_x;
  logic [SAMPLE_W-1:0] in_sample_y;
  logic                out_valid;
  logic                out_stall;
  logic [WIN_W-1:0]    out_avg_x;
  logic [WIN_W-1:0]    out_avg_y;
  logic [PIX_W-1:0]    out_pixel_x;
  logic [PIX_W-1:0]    out_pixel_y;
  logic                out_none_counted;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_W-1:0]    cfg_index;
  logic [WIN_W-1:0]    cfg_data;

  // predicted register contents and burst state
  logic [WIN_W-1:0] win_x_lo = tsfm_pkg::RST_X_LOW;
  logic [WIN_W-1:0] win_x_hi = tsfm_pkg::RST_X_HIGH;
  logic [WIN_W-1:0] win_y_lo = tsfm_pkg::RST_Y_LOW;
  logic [WIN_W-1:0] win_y_hi = tsfm_pkg::RST_Y_HIGH;
  int               burst_len = int'(tsfm_pkg::RST_BURST);
  logic             rot = 1'b0;
  logic [WIN_W-1:0] scr_w = tsfm_pkg::RST_SCREEN_W;
  logic [WIN_W-1:0] scr_h = tsfm_pkg::RST_SCREEN_H;
  int               sum_x = 0;
  int               sum_y = 0;
  int               hits = 0;
  int               seen = 0;

  position_t positions_due[$];
  int        errors = 0;
  int        items_sent = 0;
  int        positions_checked = 0;
  int        settings_used = 1;
  int        cycle_count = 0;
  bit        hold_start = 1'b0;

  touch_sample_filter_and_map dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_x      (in_sample_x),
    .in_sample_y      (in_sample_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_avg_x        (out_avg_x),
    .out_avg_y        (out_avg_y),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_none_counted (out_none_counted),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint screen_extent(input logic [WIN_W-1:0] s);
    if (s == '0) return 1;
    if (s > tsfm_pkg::MAX_SCREEN) return longint'(tsfm_pkg::MAX_SCREEN);
    return longint'(s);
  endfunction

  // size*(pos - lo)/span, truncating toward zero; ok is low for an empty window
  function automatic longint map_axis(input longint pos, input longint lo, input longint hi,
                                      input longint size, output bit ok);
    longint span;
    span = hi - lo;
    ok = (span > 0);
    if (!ok) return 0;
    return size * (pos - lo) / span;
  endfunction

  function automatic logic [PIX_W-1:0] clamp_pixel(input longint p, input longint size);
    longint c;
    c = p;
    if (c < 0) c = 0;
    if (c > size - 1) c = size - 1;
    return c[PIX_W-1:0];
  endfunction

  // sums one pair into the burst; on the closing pair queues the expected position
  function automatic void fold_sample_pair(input logic [SAMPLE_W-1:0] sx,
                                           input logic [SAMPLE_W-1:0] sy);
    position_t pos;
    longint    ax, ay, w, h, px, py;
    bit        okx, oky;
    if (sx > win_x_lo && sx < win_x_hi && sy > win_y_lo && sy < win_y_hi) begin
      sum_x += int'(sx);
      sum_y += int'(sy);
      hits++;
    end
    seen++;
    if (seen < burst_len) return;
    ax = 0;
    ay = 0;
    if (hits > 0) begin
      ax = sum_x / hits;
      ay = sum_y / hits;
    end
    w = screen_extent(scr_w);
    h = screen_extent(scr_h);
    if (!rot) begin
      px = map_axis(ax, longint'(win_x_lo), longint'(win_x_hi), w, okx);
      py = map_axis(ay, longint'(win_y_lo), longint'(win_y_hi), h, oky);
    end else begin
      px = w - map_axis(ay, longint'(win_y_lo), longint'(win_y_hi), w, okx);
      py = map_axis(ax, longint'(win_x_lo), longint'(win_x_hi), h, oky);
    end
    pos.avg_x   = ax[WIN_W-1:0];
    pos.avg_y   = ay[WIN_W-1:0];
    pos.pixel_x = okx ? clamp_pixel(px, w) : '0;
    pos.pixel_y = oky ? clamp_pixel(py, h) : '0;
    pos.none    = (hits == 0);
    positions_due.push_back(pos);
    sum_x = 0;
    sum_y = 0;
    hits = 0;
    seen = 0;
  endfunction

  function automatic void check_field(input string name, input logic [WIN_W-1:0] want,
                                      input logic [WIN_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    position_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (positions_due.size() == 0) begin
        errors++;
        $display("%0t unexpected position: expected none, actual avg %0d,%0d pixel %0d,%0d",
                 $time, out_avg_x, out_avg_y, out_pixel_x, out_pixel_y);
      end else begin
        want = positions_due.pop_front();
        positions_checked++;
        check_field("avg_x", want.avg_x, out_avg_x);
        check_field("avg_y", want.avg_y, out_avg_y);
        check_field("pixel_x", WIN_W'(want.pixel_x), WIN_W'(out_pixel_x));
        check_field("pixel_y", WIN_W'(want.pixel_y), WIN_W'(out_pixel_y));
        check_field("none_counted", WIN_W'(want.none), WIN_W'(out_none_counted));
      end
    end
  end

  // receiver: stall pattern in segments, plus a long hold-off on request
  initial begin : receiver
    int          seg;
    stall_mode_t mode;
    seg = 0;
    mode = STALL_NONE;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        seg = 0;
      end
      if (seg == 0) begin
        seg = int'($urandom_range(1, 40));
        mode = stall_mode_t'($urandom_range(0, 3));
      end
      seg--;
      case (mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d positions still due", cycle_count,
             positions_due.size());
    $display("status: fail");
    $finish;
  end

  // one request on the sample channel; valid stays high for a following pair
  task automatic send_pair(input logic [SAMPLE_W-1:0] sx, input logic [SAMPLE_W-1:0] sy);
    in_valid <= 1'b1;
    in_sample_x <= sx;
    in_sample_y <= sy;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    fold_sample_pair(sx, sy);
    items_sent++;
  endtask

  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (positions_due.size() != 0) @(posedge clk);
  endtask

  // block must be idle before a register write: a pair that closes no burst gives no result
  task automatic drain_and_settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WIN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(posedge clk);
    end while (cfg_ready !== 1'b1);
    case (idx)
      tsfm_pkg::REG_X_LOW:    win_x_lo = data;
      tsfm_pkg::REG_X_HIGH:   win_x_hi = data;
      tsfm_pkg::REG_Y_LOW:    win_y_lo = data;
      tsfm_pkg::REG_Y_HIGH:   win_y_hi = data;
      tsfm_pkg::REG_BURST: begin
        if (data[5:0] >= 6'd1 && data[5:0] <= 6'(BURST_MAX)) burst_len = int'(data[5:0]);
      end
      tsfm_pkg::REG_ROTATED:  rot = data[0];
      tsfm_pkg::REG_SCREEN_W: scr_w = data;
      tsfm_pkg::REG_SCREEN_H: scr_h = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void pick_window(output logic [WIN_W-1:0] lo, output logic [WIN_W-1:0] hi);
    case ($urandom_range(0, 5))
      0: begin
        lo = 12'd0;
        hi = 12'd4095;
      end
      1: begin
        lo = WIN_W'($urandom_range(0, 1500));
        hi = WIN_W'($urandom_range(2500, 4095));
      end
      2: begin
        // narrow window, at most a couple of values inside
        lo = WIN_W'($urandom_range(0, 4092));
        hi = lo + WIN_W'($urandom_range(1, 3));
      end
      3: begin
        // empty window, high at or below low
        lo = WIN_W'($urandom_range(0, 4095));
        hi = WIN_W'($urandom_range(0, lo));
      end
      4: begin
        lo = WIN_W'($urandom());
        hi = WIN_W'($urandom());
      end
      default: begin
        lo = WIN_W'($urandom_range(100, 400));
        hi = WIN_W'($urandom_range(3300, 3900));
      end
    endcase
  endfunction

  function automatic logic [WIN_W-1:0] pick_size();
    case ($urandom_range(0, 5))
      0: return WIN_W'(1);
      1: return tsfm_pkg::MAX_SCREEN;
      2: return '0;
      3: return WIN_W'($urandom_range(2049, 4095));
      4: return WIN_W'($urandom_range(1, 2048));
      default: return WIN_W'($urandom_range(1, 800));
    endcase
  endfunction

  // mostly inside the window so that bursts get averaged, sometimes on the edges or anywhere
  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [WIN_W-1:0] lo,
                                                      input logic [WIN_W-1:0] hi);
    case ($urandom_range(0, 9))
      0: return SAMPLE_W'($urandom());
      1: return $urandom_range(0, 1) ? lo : hi;
      default: return (hi > lo + 1) ? SAMPLE_W'($urandom_range(hi - 1, lo + 1))
                                     : SAMPLE_W'($urandom());
    endcase
  endfunction

  task automatic test_defaults();
    send_pair(12'd301, 12'd216);
    send_pair(12'd300, 12'd216);
    send_pair(12'd3749, 12'd3439);
    send_pair(12'd3750, 12'd3439);
    send_pair(12'd0, 12'd0);
    send_pair(12'd4095, 12'd4095);
    send_pair(12'd2000, 12'd1800);
  endtask

  task automatic test_rotation_and_none();
    drain_and_settle();
    write_reg(tsfm_pkg::REG_ROTATED, 12'd1);
    write_reg(tsfm_pkg::REG_BURST, 12'd2);
    settings_used++;
    send_pair(12'd0, 12'd0);
    send_pair(12'd4095, 12'd4095);
    send_pair(12'd1000, 12'd1000);
    send_pair(12'd1002, 12'd1003);
  endtask

  task automatic test_clamps_and_empty_window();
    drain_and_settle();
    // out-of-range burst lengths keep the previous value
    write_reg(tsfm_pkg::REG_BURST, 12'd0);
    write_reg(tsfm_pkg::REG_BURST, 12'd51);
    write_reg(tsfm_pkg::REG_SCREEN_W, 12'd0);
    write_reg(tsfm_pkg::REG_SCREEN_H, 12'd4095);
    write_reg(tsfm_pkg::REG_ROTATED, 12'd0);
    write_reg(tsfm_pkg::REG_X_LOW, 12'd2000);
    write_reg(tsfm_pkg::REG_X_HIGH, 12'd2000);
    settings_used++;
    send_pair(12'd2000, 12'd500);
    send_pair(12'd2100, 12'd600);
    drain_and_settle();
    write_reg(tsfm_pkg::REG_ROTATED, 12'd1);
    settings_used++;
    send_pair(12'd1999, 12'd3000);
    send_pair(12'd2001, 12'd3100);
  endtask

  task automatic test_burst_change();
    drain_and_settle();
    write_reg(tsfm_pkg::REG_X_LOW, 12'd0);
    write_reg(tsfm_pkg::REG_X_HIGH, 12'd4095);
    write_reg(tsfm_pkg::REG_Y_LOW, 12'd0);
    write_reg(tsfm_pkg::REG_Y_HIGH, 12'd4095);
    write_reg(tsfm_pkg::REG_SCREEN_W, 12'd2048);
    write_reg(tsfm_pkg::REG_SCREEN_H, 12'd2048);
    write_reg(tsfm_pkg::REG_ROTATED, 12'd0);
    write_reg(tsfm_pkg::REG_BURST, 12'd5);
    write_reg(tsfm_pkg::REG_BURST, 12'd63);
    settings_used++;
    send_pair(12'd4094, 12'd4094);
    send_pair(12'd1, 12'd1);
    send_pair(12'd4094, 12'd1);
    // shorten the burst after three pairs: the next pair closes it
    drain_and_settle();
    write_reg(tsfm_pkg::REG_BURST, 12'd2);
    settings_used++;
    send_pair(12'd2048, 12'd2048);
  endtask

  task automatic test_backpressure();
    int n;
    drain_and_settle();
    write_reg(tsfm_pkg::REG_BURST, 12'd1);
    settings_used++;
    hold_start = 1'b1;
    for (n = 0; n < 24; n++) send_pair(pick_sample(win_x_lo, win_x_hi),
                                       pick_sample(win_y_lo, win_y_hi));
    wait_for_results();
  endtask

  task automatic test_random();
    int               phase, n, burst_left;
    logic [WIN_W-1:0] xl, xh, yl, yh, blen, rot_v, sw, sh;
    for (phase = 0; phase < PHASES; phase++) begin
      drain_and_settle();
      if (phase == 0) begin
        xl = 12'd0; xh = 12'd4095; yl = 12'd0; yh = 12'd4095;
        blen = WIN_W'(BURST_MAX); rot_v = 12'd0;
        sw = tsfm_pkg::MAX_SCREEN; sh = tsfm_pkg::MAX_SCREEN;
      end else if (phase == 1) begin
        xl = 12'd4095; xh = 12'd0; yl = 12'd0; yh = 12'd4095;
        blen = 12'd1; rot_v = 12'd1; sw = 12'd1; sh = 12'd1;
      end else begin
        pick_window(xl, xh);
        pick_window(yl, yh);
        case ($urandom_range(0, 4))
          0: blen = WIN_W'($urandom_range(1, 3));
          1: blen = WIN_W'($urandom_range(1, 10));
          2: blen = WIN_W'($urandom_range(1, BURST_MAX));
          3: blen = WIN_W'(BURST_MAX);
          default: blen = WIN_W'($urandom());
        endcase
        rot_v = WIN_W'($urandom_range(0, 1));
        sw = pick_size();
        sh = pick_size();
      end
      write_reg(tsfm_pkg::REG_X_LOW, xl);
      write_reg(tsfm_pkg::REG_X_HIGH, xh);
      write_reg(tsfm_pkg::REG_Y_LOW, yl);
      write_reg(tsfm_pkg::REG_Y_HIGH, yh);
      write_reg(tsfm_pkg::REG_BURST, blen);
      write_reg(tsfm_pkg::REG_ROTATED, rot_v);
      write_reg(tsfm_pkg::REG_SCREEN_W, sw);
      write_reg(tsfm_pkg::REG_SCREEN_H, sh);
      settings_used++;
      burst_left = 0;
      for (n = 0; n < PAIRS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 19) == 0) wait_for_results();
          idle_for(($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12)));
          burst_left = int'($urandom_range(1, 24));
        end
        burst_left--;
        send_pair(pick_sample(win_x_lo, win_x_hi), pick_sample(win_y_lo, win_y_hi));
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_sample_x <= '0;
    in_sample_y <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= tsfm_pkg::REG_X_LOW;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_rotation_and_none();
    test_clamps_and_empty_window();
    test_burst_change();
    test_backpressure();
    test_random();
    drain_and_settle();
    $display("covered %0d sample pairs under %0d register settings, %0d positions compared",
             items_sent, settings_used, positions_checked);
    $display("including empty windows, rotation, size clamps and a long output hold-off");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
